// ----- sv/sobel_et_pkg.sv -----
// Shared types, constants and helpers for the Sobel edge threshold filter.
package sobel_et_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned ROW_W         = $clog2(HEIGHT_LIMIT);

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned FW_W          = 11;
  localparam int unsigned FH_W          = 13;
  localparam int unsigned SUM_W         = 12;

  localparam int unsigned RESET_WIDTH     = 640;
  localparam int unsigned RESET_HEIGHT    = 480;
  localparam logic [PIX_W-1:0] RESET_THRESHOLD = 8'd250;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } stage_ctrl_t;

  // Last valid index for a size clamped to 3..lim.
  function automatic int unsigned last_index(int unsigned v, int unsigned lim);
    int unsigned r;
    if (v < 3) begin
      r = 2;
    end else if (v > lim) begin
      r = lim - 1;
    end else begin
      r = v - 1;
    end
    return r;
  endfunction

  // Saturate a signed kernel sum to 0..255.
  function automatic logic [PIX_W-1:0] clip8(logic signed [SUM_W-1:0] s);
    logic [PIX_W-1:0] r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (|s[SUM_W-2:PIX_W]) begin
      r = '1;
    end else begin
      r = s[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/sobel_et_linebuf.sv -----
// Two line stores in synchronous RAM with read-after-write forwarding.
module sobel_et_linebuf import sobel_et_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_col_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_col_i,
  input  logic [PIX_W-1:0] wr_up_i,
  input  logic [PIX_W-1:0] wr_mid_i,
  output logic [PIX_W-1:0] up_o,
  output logic [PIX_W-1:0] mid_o
);

  logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

  logic [PIX_W-1:0] rd_up_q, rd_mid_q;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_up[wr_col_i]  <= wr_up_i;
      mem_mid[wr_col_i] <= wr_mid_i;
    end
    if (rd_en_i) begin
      rd_up_q  <= mem_up[rd_col_i];
      rd_mid_q <= mem_mid[rd_col_i];
    end
    if (wr_en_i) begin
      fwd_up_q  <= wr_up_i;
      fwd_mid_q <= wr_mid_i;
    end
  end

  // Same entry read and written on one edge: RAM returns old data, take the new.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_en_i) begin
      hit_q <= wr_en_i && (wr_col_i == rd_col_i);
    end
  end

  assign up_o  = hit_q ? fwd_up_q  : rd_up_q;
  assign mid_o = hit_q ? fwd_mid_q : rd_mid_q;

endmodule

// ----- sv/sobel_et_kernel.sv -----
// 3x3 window, kernel sums, clipping, threshold and output register.
module sobel_et_kernel import sobel_et_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  stage_ctrl_t      s1_ctrl_i,
  input  logic [PIX_W-1:0] pix_i,
  input  logic [PIX_W-1:0] up_i,
  input  logic [PIX_W-1:0] mid_i,
  input  logic [PIX_W-1:0] threshold_i,
  output logic             out_valid_o,
  output logic [PIX_W-1:0] edge_value_o,
  output logic             frame_last_o
);

  function automatic logic signed [SUM_W-1:0] sx(logic [PIX_W-1:0] v);
    return signed'(SUM_W'(v));
  endfunction

  logic [PIX_W-1:0] win_q [6];

  logic signed [SUM_W-1:0] sum_h, sum_d1, sum_d2;
  logic signed [SUM_W-1:0] h_q, d1_q, d2_q;
  logic                    s2_valid_q, s2_last_q;

  logic [PIX_W-1:0] c_h, c_d1, c_d2, best;

  logic             out_valid_q, out_last_q;
  logic [PIX_W-1:0] out_edge_q;

  // p[row][col]: row 0 oldest line, col 2 newest column.
  always_comb begin
    sum_h  = sx(win_q[0]) + (sx(win_q[2]) <<< 1) + sx(win_q[4])
           - sx(up_i) - (sx(mid_i) <<< 1) - sx(pix_i);
    sum_d1 = (sx(up_i) <<< 1) + sx(mid_i) + sx(win_q[1])
           - sx(win_q[2]) - (sx(win_q[4]) <<< 1) - sx(win_q[5]);
    sum_d2 = sx(win_q[2]) + (sx(win_q[4]) <<< 1) + sx(win_q[5])
           - (sx(up_i) <<< 1) - sx(mid_i) - sx(win_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv_i && s1_ctrl_i.valid) begin
      win_q[0] <= win_q[1];
      win_q[1] <= up_i;
      win_q[2] <= win_q[3];
      win_q[3] <= mid_i;
      win_q[4] <= win_q[5];
      win_q[5] <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_ctrl_i.valid && s1_ctrl_i.interior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h_q       <= sum_h;
      d1_q      <= sum_d1;
      d2_q      <= sum_d2;
      s2_last_q <= s1_ctrl_i.last;
    end
  end

  always_comb begin
    c_h  = clip8(h_q);
    c_d1 = clip8(d1_q);
    c_d2 = clip8(d2_q);
    best = c_h;
    if (c_d1 > best) begin
      best = c_d1;
    end
    if (c_d2 > best) begin
      best = c_d2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s2_valid_q) begin
      out_edge_q <= (best > threshold_i) ? best : '0;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_value_o = out_edge_q;
  assign frame_last_o = out_last_q;

endmodule

// ----- sv/sobel_edge_threshold_filter.sv -----
// Top level of the streaming 3x3 Sobel edge filter with strength threshold.
//
// Usage:
//  - Input channel: one 8-bit pixel word per accepted beat, raster order.
//    A word is taken at a rising edge with in_valid_i high and in_stall_o low.
//    frame_start_i on a word zeroes the column and row counters first.
//  - Output channel: one word per interior pixel (not first/last row or
//    column); border pixels yield nothing. frame_last_o marks the word of the
//    last interior pixel of a frame. Taken when out_valid_o && !out_stall_i.
//  - Config channel: cfg_index_i selects width (0), height (1) or threshold
//    (2); other indexes are dropped. cfg_ready_o is always high. Write only
//    while the pipe is empty. Sizes are clamped to 3..MAX_WIDTH / 3..4096.
//  - Throughput: one word per clock while not stalled. Each pixel does a single
//    read of both line-store RAMs and one write back as it leaves stage 1,
//    so the RAM ports are busy every cycle; same-entry overlap is forwarded.
//  - Pipeline: the result for the input word that completes its window goes
//    through the RAM read, kernel sums and output register to out_valid_o.
//  - Stall: a stalled output word holds; the whole pipe freezes, and
//    in_stall_o rises, only while the output register is full and stalled.
//  - Reset: counters, window and valid bits clear at once; registers go to
//    640 x 480, threshold 250. Line stores are not cleared and need no pass.
module sobel_edge_threshold_filter import sobel_et_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic                  frame_start_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      edge_value_o,
  output logic                  frame_last_o,
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [COL_W-1:0] RST_LAST_COL =
    COL_W'(last_index(RESET_WIDTH, MAX_WIDTH));
  localparam logic [ROW_W-1:0] RST_LAST_ROW =
    ROW_W'(last_index(RESET_HEIGHT, HEIGHT_LIMIT));

  // Effective sizes are kept as last indexes, clamped when written.
  logic [COL_W-1:0] last_col_q, last_col_d;
  logic [ROW_W-1:0] last_row_q, last_row_d;
  logic [PIX_W-1:0] thresh_q;

  logic [COL_W-1:0] col_q, col_d, col_cur, col_eff;
  logic [ROW_W-1:0] row_q, row_d, row_cur, row_eff;
  logic             line_end, row_end;

  logic             adv, accept, lb_wr_en;
  logic             k_out_valid;

  stage_ctrl_t      s1_ctrl_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;

  logic [PIX_W-1:0] lb_up, lb_mid;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    last_col_d = COL_W'(last_index(32'(cfg_data_i[FW_W-1:0]), MAX_WIDTH));
    last_row_d = ROW_W'(last_index(32'(cfg_data_i[FH_W-1:0]), HEIGHT_LIMIT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= RST_LAST_COL;
      last_row_q <= RST_LAST_ROW;
      thresh_q   <= RESET_THRESHOLD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:    last_col_q <= last_col_d;
        CFG_FRAME_HEIGHT:   last_row_q <= last_row_d;
        CFG_EDGE_THRESHOLD: thresh_q   <= cfg_data_i[PIX_W-1:0];
        default:            ;
      endcase
    end
  end

  // Global pipe enable: only a full, stalled output register holds things up.
  assign adv        = !k_out_valid || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // Position of the incoming word; counts past a shrunk size end the line/frame.
  always_comb begin
    col_cur  = frame_start_i ? '0 : col_q;
    row_cur  = frame_start_i ? '0 : row_q;
    line_end = (col_cur >= last_col_q);
    row_end  = (row_cur >= last_row_q);
    col_eff  = line_end ? last_col_q : col_cur;
    row_eff  = row_end ? last_row_q : row_cur;
    if (line_end && row_end) begin
      col_d = '0;
      row_d = '0;
    end else if (line_end) begin
      col_d = '0;
      row_d = row_eff + 1'b1;
    end else begin
      col_d = col_eff + 1'b1;
      row_d = row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: waiting on the line-store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
    end else if (adv) begin
      s1_ctrl_q.valid    <= accept;
      s1_ctrl_q.interior <= (col_eff >= COL_W'(2)) && (row_eff >= ROW_W'(2));
      s1_ctrl_q.last     <= line_end && row_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pixel_value_i;
      s1_col_q <= col_eff;
    end
  end

  // Write back: middle line moves up, new pixel becomes the middle line.
  assign lb_wr_en = adv && s1_ctrl_q.valid;

  sobel_et_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_col_i (col_eff),
    .wr_en_i  (lb_wr_en),
    .wr_col_i (s1_col_q),
    .wr_up_i  (lb_mid),
    .wr_mid_i (s1_pix_q),
    .up_o     (lb_up),
    .mid_o    (lb_mid)
  );

  sobel_et_kernel u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .s1_ctrl_i    (s1_ctrl_q),
    .pix_i        (s1_pix_q),
    .up_i         (lb_up),
    .mid_i        (lb_mid),
    .threshold_i  (thresh_q),
    .out_valid_o  (k_out_valid),
    .edge_value_o (edge_value_o),
    .frame_last_o (frame_last_o)
  );

  assign out_valid_o = k_out_valid;

endmodule

// ----- sv/sobel_et_chk.sv -----
// Port-level checker for the Sobel edge filter, bound to the top level.
module sobel_et_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] edge_value_o,
  input logic       frame_last_o
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(edge_value_o)
      && $stable(frame_last_o))
    else $error("stalled output word changed");

  // Input backpressure only comes from a full, stalled output register.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A result word that follows an empty output only loads on an edge where the pipe advanced.
  a_load_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("output loaded while pipe was frozen");

endmodule

bind sobel_edge_threshold_filter sobel_et_chk u_sobel_et_chk (.*);
